// File: rtl/qcdd_pkg.sv
`default_nettype none
package qcdd_pkg;

	localparam int CordicSteps = 24;
	localparam int DatBits     = 34;
	localparam int StepBits    = $clog2(CordicSteps);

	localparam logic signed [DatBits-1:0] PI_Q28      = 34'sd843314857;
	localparam logic signed [DatBits-1:0] TWO_PI_Q28  = 34'sd1686629713;
	localparam logic signed [DatBits-1:0] HALF_PI_Q28 = 34'sd421657428;
	localparam logic signed [DatBits-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [2:0] REG_DIST_PER_TICK = 3'd0;
	localparam logic [2:0] REG_INV_WHEELBASE = 3'd1;
	localparam logic [2:0] REG_START_X       = 3'd2;
	localparam logic [2:0] REG_START_Y       = 3'd3;
	localparam logic [2:0] REG_START_HEADING = 3'd4;

	localparam logic [1:0] EDGE_RISE = 2'd1;
	localparam logic [1:0] EDGE_FALL = 2'd2;

	// atan(2^-i) in Q3.28, rounded to nearest
	function automatic logic signed [DatBits-1:0] cordic_atan(input logic [StepBits-1:0] i);
		logic signed [DatBits-1:0] r;
		case (i)
			5'd0:    r = 34'sd210828714;
			5'd1:    r = 34'sd124459457;
			5'd2:    r = 34'sd65760959;
			5'd3:    r = 34'sd33381290;
			5'd4:    r = 34'sd16755422;
			5'd5:    r = 34'sd8385879;
			5'd6:    r = 34'sd4193963;
			5'd7:    r = 34'sd2097109;
			5'd8:    r = 34'sd1048571;
			5'd9:    r = 34'sd524287;
			default: r = 34'sd1 <<< (5'd28 - i);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/quadrature_count_diff_drive_odometry_core.sv
`default_nettype none
// Two-wheel quadrature edge counter with differential-drive dead reckoning.
// Input channel (in_valid/in_ready): each beat is either an encoder edge
// event (kind 0) or an odometry request (kind 1). An edge event with a rise
// or fall code moves the signed count of the selected wheel by one in the
// next cycle and yields no result beat; other codes are ignored. The block
// stays ready, so edge events run one per cycle. An odometry request drops
// in_ready for its whole run: two multiplies for wheel distance, two for
// the turn, a wrap and fold of the angle, 24 CORDIC rotations (one per cycle
// on a shared add/shift unit), and four multiplies for the x/y advance, all
// on one 34x34 multiplier. The CORDIC loop takes most of the run, and no
// new beat is accepted until the result has moved to the output register.
// Output channel (out_valid/out_ready): one beat per request carrying pose
// and both counts, held in a register. Edge events are still accepted while
// a result beat waits; a following request runs and then holds its final
// step until the waiting beat is taken.
// Configuration channel (cfg_valid/cfg_ready): always ready; writing a start
// register loads the matching pose value. Write only while idle.
// Reset clears counts, pose and heading, sets inverse_wheelbase to 1.0 and
// distance_per_tick to zero; no result is pending after reset.
module quadrature_count_diff_drive_odometry_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               kind,
	input  wire logic               wheel_select,
	input  wire logic               channel_select,
	input  wire logic [1:0]         edge_code,
	input  wire logic               other_level,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      pose_x,
	output logic signed [31:0]      pose_y,
	output logic signed [30:0]      pose_heading,
	output logic signed [31:0]      left_total,
	output logic signed [31:0]      right_total,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE, S_ML, S_MR, S_SUM, S_T0, S_T1, S_T2, S_ANG, S_WRAP, S_FOLD,
		S_ROT, S_NEG, S_XL, S_XH, S_YL, S_YH, S_FIN
	} state_t;

	localparam int DW = qcdd_pkg::DatBits;
	localparam int SW = qcdd_pkg::StepBits;

	state_t state_q;

	logic [31:0] dpt_q, iwb_q;
	logic [31:0] left_count_q, right_count_q, left_prev_q, right_prev_q;
	logic [31:0] pos_x_q, pos_y_q, heading_q;

	// datapath registers (no reset)
	logic signed [2*DW-1:0] prod_q;
	logic signed [47:0]     dl_q;
	logic [43:0]            diff_q;
	logic signed [47:0]     mean_q;
	logic [61:0]            acc_q;
	logic [31:0]            turn_q;
	logic [31:0]            hnew_q;
	logic signed [DW-1:0]   x_q, y_q, z_q;
	logic [SW-1:0]          i_q;
	logic                   flip_q;

	logic                   mul_en;
	logic signed [DW-1:0]   mul_a, mul_b;
	logic [31:0]            dl_tick, dr_tick;
	logic signed [48:0]     sum49, diff49;
	logic [43:0]            turn44;
	logic [31:0]            ang32;
	logic signed [DW-1:0]   ang_s, hnew_s;
	logic signed [DW-1:0]   xs, ys, atan_i;
	logic [61:0]            adv;
	logic                   rise, up, edge_ok, out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || out_ready;

	assign dl_tick = left_count_q - left_prev_q;
	assign dr_tick = right_count_q - right_prev_q;

	assign rise    = (edge_code == qcdd_pkg::EDGE_RISE);
	assign edge_ok = (edge_code == qcdd_pkg::EDGE_RISE) || (edge_code == qcdd_pkg::EDGE_FALL);
	assign up      = channel_select ? (rise != other_level) : (rise == other_level);

	assign sum49  = {prod_q[63], prod_q[63:16]} + {dl_q[47], dl_q};
	assign diff49 = {prod_q[63], prod_q[63:16]} - {dl_q[47], dl_q};
	assign turn44 = {prod_q[21:0], 22'd0} + acc_q[43:0];
	assign ang32  = heading_q + {turn_q[31], turn_q[31:1]};
	assign ang_s  = z_q;
	assign hnew_s = DW'($signed(hnew_q));
	assign xs     = x_q >>> i_q;
	assign ys     = y_q >>> i_q;
	assign atan_i = qcdd_pkg::cordic_atan(i_q);
	assign adv    = {prod_q[37:0], 24'd0} + acc_q;

	// shared multiplier operand select
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_ML: begin
				mul_a = DW'($signed(dl_tick));
				mul_b = {2'b00, dpt_q};
			end
			S_MR: begin
				mul_a = DW'($signed(dr_tick));
				mul_b = {2'b00, dpt_q};
			end
			S_T0: begin
				mul_a = {12'd0, diff_q[21:0]};
				mul_b = {2'b00, iwb_q};
			end
			S_T1: begin
				mul_a = {12'd0, diff_q[43:22]};
				mul_b = {2'b00, iwb_q};
			end
			S_XL: begin
				mul_a = {10'd0, mean_q[23:0]};
				mul_b = x_q;
			end
			S_XH: begin
				mul_a = DW'($signed(mean_q[47:24]));
				mul_b = x_q;
			end
			S_YL: begin
				mul_a = {10'd0, mean_q[23:0]};
				mul_b = y_q;
			end
			S_YH: begin
				mul_a = DW'($signed(mean_q[47:24]));
				mul_b = y_q;
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (state_q)
			S_MR: dl_q <= prod_q[63:16];
			S_SUM: begin
				diff_q <= diff49[43:0];
				mean_q <= sum49[48:1];
			end
			S_T1: acc_q <= prod_q[61:0];
			S_T2: turn_q <= turn44[43:12];
			S_ANG: begin
				z_q    <= DW'($signed(ang32));
				hnew_q <= heading_q + turn_q;
			end
			S_WRAP: begin
				// bring angle and new heading into [-pi, pi], once
				if (ang_s > qcdd_pkg::PI_Q28) begin
					z_q <= ang_s - qcdd_pkg::TWO_PI_Q28;
				end else if (ang_s < -qcdd_pkg::PI_Q28) begin
					z_q <= ang_s + qcdd_pkg::TWO_PI_Q28;
				end
				if (hnew_s > qcdd_pkg::PI_Q28) begin
					hnew_q <= 32'(hnew_s - qcdd_pkg::TWO_PI_Q28);
				end else if (hnew_s < -qcdd_pkg::PI_Q28) begin
					hnew_q <= 32'(hnew_s + qcdd_pkg::TWO_PI_Q28);
				end
			end
			S_FOLD: begin
				// fold into [-pi/2, pi/2]; cos and sin flip sign
				x_q    <= qcdd_pkg::CORDIC_GAIN;
				y_q    <= '0;
				i_q    <= '0;
				flip_q <= 1'b0;
				if (ang_s > qcdd_pkg::HALF_PI_Q28) begin
					z_q    <= ang_s - qcdd_pkg::PI_Q28;
					flip_q <= 1'b1;
				end else if (ang_s < -qcdd_pkg::HALF_PI_Q28) begin
					z_q    <= ang_s + qcdd_pkg::PI_Q28;
					flip_q <= 1'b1;
				end
			end
			S_ROT: begin
				i_q <= i_q + 1'b1;
				if (z_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_i;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_i;
				end
			end
			S_NEG: begin
				if (flip_q) begin
					x_q <= -x_q;
					y_q <= -y_q;
				end
			end
			S_XH: acc_q <= prod_q[61:0];
			S_YH: acc_q <= prod_q[61:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid     <= 1'b0;
			dpt_q         <= '0;
			iwb_q         <= 32'd16777216;
			left_count_q  <= '0;
			right_count_q <= '0;
			left_prev_q   <= '0;
			right_prev_q  <= '0;
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			heading_q     <= '0;
			pose_x        <= '0;
			pose_y        <= '0;
			pose_heading  <= '0;
			left_total    <= '0;
			right_total   <= '0;
		end else begin
			// raise on a finished request, drop once the beat is taken
			if (state_q == S_FIN && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					qcdd_pkg::REG_DIST_PER_TICK: dpt_q <= cfg_data;
					qcdd_pkg::REG_INV_WHEELBASE: iwb_q <= cfg_data;
					qcdd_pkg::REG_START_X:       pos_x_q <= cfg_data;
					qcdd_pkg::REG_START_Y:       pos_y_q <= cfg_data;
					qcdd_pkg::REG_START_HEADING: heading_q <= {cfg_data[30], cfg_data[30:0]};
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (kind) begin
							state_q <= S_ML;
						end else if (edge_ok) begin
							if (wheel_select) begin
								right_count_q <= up ? right_count_q + 1'b1 : right_count_q - 1'b1;
							end else begin
								left_count_q <= up ? left_count_q + 1'b1 : left_count_q - 1'b1;
							end
						end
					end
				end
				S_ML:   state_q <= S_MR;
				S_MR:   state_q <= S_SUM;
				S_SUM:  state_q <= S_T0;
				S_T0:   state_q <= S_T1;
				S_T1:   state_q <= S_T2;
				S_T2:   state_q <= S_ANG;
				S_ANG:  state_q <= S_WRAP;
				S_WRAP: state_q <= S_FOLD;
				S_FOLD: state_q <= S_ROT;
				S_ROT: begin
					if (i_q == SW'(qcdd_pkg::CordicSteps - 1)) begin
						state_q <= S_NEG;
					end
				end
				S_NEG: state_q <= S_XL;
				S_XL:  state_q <= S_XH;
				S_XH:  state_q <= S_YL;
				S_YL: begin
					pos_x_q <= pos_x_q + adv[61:30];
					state_q <= S_YH;
				end
				S_YH: state_q <= S_FIN;
				S_FIN: begin
					// hold until the previous result beat is gone
					if (out_free) begin
						pos_y_q      <= pos_y_q + adv[61:30];
						heading_q    <= hnew_q;
						left_prev_q  <= left_count_q;
						right_prev_q <= right_count_q;
						pose_x       <= pos_x_q;
						pose_y       <= pos_y_q + adv[61:30];
						pose_heading <= hnew_q[30:0];
						left_total   <= left_count_q;
						right_total  <= right_count_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/qcdd_checker.sv
`default_nettype none
module qcdd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        kind,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] pose_x,
	input wire logic [31:0] pose_y
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pose_x) && $stable(pose_y))
		else $error("result beat changed while stalled");

	// an odometry request makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind |=> !in_ready)
		else $error("ready after odometry request");

	// a new result only appears at the end of a busy run
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result beat without odometry run");

endmodule

bind quadrature_count_diff_drive_odometry_core qcdd_checker u_qcdd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.kind      (kind),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pose_x    (pose_x),
	.pose_y    (pose_y)
);
`default_nettype wire

// File: verif/quadrature_count_diff_drive_odometry_core_tb.sv
`default_nettype none
module quadrature_count_diff_drive_odometry_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 2000000;
	localparam int SettleCycles = 60;
	localparam longint QUARTER_ANGLE = 210828714;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [30:0] heading;
		logic [31:0] left;
		logic [31:0] right;
	} pose_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic wheel_select = 1'b0;
	logic channel_select = 1'b0;
	logic [1:0] edge_code = 2'd0;
	logic other_level = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic signed [30:0] pose_heading;
	logic signed [31:0] left_total;
	logic signed [31:0] right_total;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = 3'd0;
	logic [31:0] cfg_data = 32'd0;

	quadrature_count_diff_drive_odometry_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .wheel_select(wheel_select), .channel_select(channel_select),
		.edge_code(edge_code), .other_level(other_level),
		.out_valid(out_valid), .out_ready(out_ready),
		.pose_x(pose_x), .pose_y(pose_y), .pose_heading(pose_heading),
		.left_total(left_total), .right_total(right_total),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow of the block's registers and state
	logic [31:0] dist_per_tick, inv_wheelbase;
	logic [31:0] left_edges, right_edges, left_mark, right_mark;
	logic [31:0] odo_x, odo_y, odo_heading;

	pose_beat_t pending_poses[$];
	int fail_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// atan(2^-i) in Q3.28 from the odd-power series, rounded to nearest
	function automatic longint atan_step(int i);
		longint unsigned sum;
		longint unsigned term;
		int k;
		int e;
		if (i == 0) begin
			return QUARTER_ANGLE;
		end
		sum = 0;
		for (k = 0; (2 * k + 1) * i <= 60; k++) begin
			e = 2 * k + 1;
			term = (64'd1 << (60 - e * i)) / e;
			if (k % 2 == 1) sum = sum - term;
			else sum = sum + term;
		end
		return longint'((sum + (64'd1 << 31)) >> 32);
	endfunction

	// Rotate the unit vector by angle ang; returns Q.30 cos and sin
	task automatic rotate_unit(input longint ang, output longint cos_v, output longint sin_v);
		longint px;
		longint py;
		longint z;
		longint xs;
		longint ys;
		longint pi_v;
		longint two_pi_v;
		longint half_pi_v;
		bit flip;
		pi_v = longint'(qcdd_pkg::PI_Q28);
		two_pi_v = longint'(qcdd_pkg::TWO_PI_Q28);
		half_pi_v = longint'(qcdd_pkg::HALF_PI_Q28);
		flip = 1'b0;
		while (ang > pi_v) ang = ang - two_pi_v;
		while (ang < -pi_v) ang = ang + two_pi_v;
		// fold into the right half plane; negate the result afterwards
		if (ang > half_pi_v) begin
			ang = ang - pi_v;
			flip = 1'b1;
		end else if (ang < -half_pi_v) begin
			ang = ang + pi_v;
			flip = 1'b1;
		end
		px = longint'(qcdd_pkg::CORDIC_GAIN);
		py = 0;
		z = ang;
		for (int i = 0; i < qcdd_pkg::CordicSteps; i++) begin
			xs = px >>> i;
			ys = py >>> i;
			if (z >= 0) begin
				px = px - ys;
				py = py + xs;
				z = z - atan_step(i);
			end else begin
				px = px + ys;
				py = py - xs;
				z = z + atan_step(i);
			end
		end
		cos_v = flip ? -px : px;
		sin_v = flip ? -py : py;
	endtask

	// Apply one accepted beat to the shadow state; queue the pose it yields
	task automatic advance_odometry(input logic k, input logic w, input logic ch,
			input logic [1:0] code, input logic lvl);
		logic [31:0] d32;
		logic [63:0] p;
		longint dl;
		longint dr;
		longint turn;
		longint mean;
		longint hd;
		longint ang;
		longint c;
		longint s;
		longint h;
		bit rise;
		bit up;
		pose_beat_t beat;
		if (k == 1'b0) begin
			if (code != qcdd_pkg::EDGE_RISE && code != qcdd_pkg::EDGE_FALL) return;
			rise = (code == qcdd_pkg::EDGE_RISE);
			up = ch ? (rise != lvl) : (rise == lvl);
			if (w) right_edges = up ? right_edges + 32'd1 : right_edges - 32'd1;
			else left_edges = up ? left_edges + 32'd1 : left_edges - 32'd1;
			return;
		end
		d32 = left_edges - left_mark;
		dl = (longint'($signed(d32)) * longint'({32'd0, dist_per_tick})) >>> 16;
		d32 = right_edges - right_mark;
		dr = (longint'($signed(d32)) * longint'({32'd0, dist_per_tick})) >>> 16;
		p = (dr - dl) * longint'({32'd0, inv_wheelbase});
		turn = longint'($signed(p[43:12]));
		mean = (dl + dr) >>> 1;
		hd = longint'($signed(odo_heading));
		p = hd + (turn >>> 1);
		ang = longint'($signed(p[31:0]));
		rotate_unit(ang, c, s);
		p = mean * c;
		odo_x = odo_x + p[61:30];
		p = mean * s;
		odo_y = odo_y + p[61:30];
		p = hd + turn;
		h = longint'($signed(p[31:0]));
		// single wrap only
		if (h > longint'(qcdd_pkg::PI_Q28)) h = h - longint'(qcdd_pkg::TWO_PI_Q28);
		else if (h < -longint'(qcdd_pkg::PI_Q28)) h = h + longint'(qcdd_pkg::TWO_PI_Q28);
		odo_heading = h[31:0];
		left_mark = left_edges;
		right_mark = right_edges;
		beat.x = odo_x;
		beat.y = odo_y;
		beat.heading = odo_heading[30:0];
		beat.left = left_edges;
		beat.right = right_edges;
		pending_poses.push_back(beat);
	endtask

	// Send one beat on the input channel, idling first at the current rate
	task automatic send_beat(input logic k, input logic w, input logic ch,
			input logic [1:0] code, input logic lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind = k;
		wheel_select = w;
		channel_select = ch;
		edge_code = code;
		other_level = lvl;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		advance_odometry(k, w, ch, code, lvl);
		@(negedge clk);
	endtask

	// Wait until every pose has come out and the block has settled
	task automatic drain();
		in_valid = 1'b0;
		while (pending_poses.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			qcdd_pkg::REG_DIST_PER_TICK: dist_per_tick = data;
			qcdd_pkg::REG_INV_WHEELBASE: inv_wheelbase = data;
			qcdd_pkg::REG_START_X:       odo_x = data;
			qcdd_pkg::REG_START_Y:       odo_y = data;
			qcdd_pkg::REG_START_HEADING: odo_heading = {data[30], data[30:0]};
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Every code, channel and opposite level, left wheel; right edges; 2 requests
	task automatic test_edge_decode();
		write_reg(qcdd_pkg::REG_DIST_PER_TICK, 32'h0100_0000);
		for (int code = 0; code < 4; code++) begin
			for (int n = 0; n < 4; n++) begin
				send_beat(1'b0, 1'b0, n[1], code[1:0], n[0]);
			end
		end
		send_beat(1'b1, 1'b0, 1'b0, 2'd0, 1'b0);
		send_beat(1'b0, 1'b1, 1'b0, qcdd_pkg::EDGE_RISE, 1'b1);
		send_beat(1'b0, 1'b1, 1'b1, qcdd_pkg::EDGE_FALL, 1'b0);
		send_beat(1'b0, 1'b1, 1'b1, qcdd_pkg::EDGE_RISE, 1'b0);
		send_beat(1'b1, 1'b1, 1'b1, 2'd3, 1'b1);
		drain();
	endtask

	// Heading and pose extremes: large turns, start values at the range ends
	task automatic test_pose_extremes();
		write_reg(qcdd_pkg::REG_DIST_PER_TICK, 32'hFFFF_FFFF);
		write_reg(qcdd_pkg::REG_INV_WHEELBASE, 32'hFFFF_FFFF);
		write_reg(qcdd_pkg::REG_START_X, 32'h7FFF_FFFF);
		write_reg(qcdd_pkg::REG_START_Y, 32'h8000_0000);
		write_reg(qcdd_pkg::REG_START_HEADING, 32'd843314857);
		repeat (3) send_beat(1'b0, 1'b1, 1'b0, qcdd_pkg::EDGE_RISE, 1'b1);
		send_beat(1'b1, 1'b0, 1'b0, 2'd0, 1'b0);
		drain();
		write_reg(qcdd_pkg::REG_START_HEADING, -32'sd843314857);
		repeat (3) send_beat(1'b0, 1'b0, 1'b0, qcdd_pkg::EDGE_RISE, 1'b1);
		send_beat(1'b1, 1'b0, 1'b0, 2'd0, 1'b0);
		send_beat(1'b1, 1'b0, 1'b0, 2'd0, 1'b0);
		drain();
		write_reg(qcdd_pkg::REG_INV_WHEELBASE, 32'd0);
		write_reg(qcdd_pkg::REG_START_X, 32'h8000_0000);
		write_reg(qcdd_pkg::REG_START_Y, 32'h7FFF_FFFF);
		repeat (2) send_beat(1'b0, 1'b1, 1'b1, qcdd_pkg::EDGE_FALL, 1'b1);
		send_beat(1'b1, 1'b0, 1'b0, 2'd0, 1'b0);
		drain();
	endtask

	// Random beats: mostly valid edges, some requests, a little ignored noise
	task automatic test_random_traffic(input int num_beats);
		int sent;
		int r;
		sent = 0;
		while (sent < num_beats) begin
			r = $urandom_range(99);
			if (r < 14) begin
				send_beat(1'b1, 1'($urandom), 1'($urandom), 2'($urandom), 1'($urandom));
			end else if (r < 20) begin
				send_beat(1'b0, 1'($urandom), 1'($urandom),
					($urandom_range(1) ? 2'd3 : 2'd0), 1'($urandom));
			end else begin
				send_beat(1'b0, 1'($urandom), 1'($urandom),
					($urandom_range(1) ? qcdd_pkg::EDGE_RISE : qcdd_pkg::EDGE_FALL),
					1'($urandom));
			end
			sent++;
		end
		drain();
	endtask

	// Walk through the idle mixes, each with its own register setting
	task automatic test_idle_phases();
		int snd_pct[5] = '{0, 57, 0, 8, 0};
		int rcv_pct[5] = '{0, 0, 57, 8, 0};
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_reg(qcdd_pkg::REG_DIST_PER_TICK, 32'hFFFF_FFFF);
					write_reg(qcdd_pkg::REG_INV_WHEELBASE, 32'd0);
				end
				2: begin
					write_reg(qcdd_pkg::REG_DIST_PER_TICK, 32'd0);
					write_reg(qcdd_pkg::REG_INV_WHEELBASE, 32'hFFFF_FFFF);
				end
				3: begin
					write_reg(qcdd_pkg::REG_DIST_PER_TICK, $urandom_range(32'h00FF_FFFF));
					write_reg(qcdd_pkg::REG_INV_WHEELBASE, 32'h0100_0000);
				end
				default: begin
					write_reg(qcdd_pkg::REG_DIST_PER_TICK, $urandom);
					write_reg(qcdd_pkg::REG_INV_WHEELBASE, $urandom);
				end
			endcase
			write_reg(qcdd_pkg::REG_START_X, $urandom);
			write_reg(qcdd_pkg::REG_START_Y, $urandom);
			write_reg(qcdd_pkg::REG_START_HEADING,
				32'($signed($urandom_range(1686629714)) - 32'sd843314857));
			send_idle_pct = snd_pct[ph];
			recv_idle_pct = rcv_pct[ph];
			test_random_traffic(385);
		end
		send_idle_pct = 0;
		recv_idle_pct = 0;
	endtask

	// Receiver: stall at the current rate, change at the falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Compare each taken pose beat with the oldest prediction
	always @(posedge clk) begin
		pose_beat_t exp_beat;
		if (arst_n && out_valid && out_ready) begin
			if (pending_poses.size() == 0) begin
				$error("pose beat with no prediction pending");
				fail_count++;
			end else begin
				exp_beat = pending_poses.pop_front();
				check_field("pose_x", exp_beat.x, pose_x);
				check_field("pose_y", exp_beat.y, pose_y);
				check_field("pose_heading", {1'b0, exp_beat.heading}, {1'b0, pose_heading});
				check_field("left_total", exp_beat.left, left_total);
				check_field("right_total", exp_beat.right, right_total);
			end
		end
	end

	// Hard stop if the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("quadrature_count_diff_drive_odometry_core_tb: FAIL");
			$finish;
		end
	end

	initial begin
		dist_per_tick = 32'd0;
		inv_wheelbase = 32'h0100_0000;
		left_edges = 32'd0;
		right_edges = 32'd0;
		left_mark = 32'd0;
		right_mark = 32'd0;
		odo_x = 32'd0;
		odo_y = 32'd0;
		odo_heading = 32'd0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_edge_decode();
		test_pose_extremes();
		test_idle_phases();
		if (pending_poses.size() != 0) begin
			$error("%0d predicted poses never came out", pending_poses.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("quadrature_count_diff_drive_odometry_core_tb: PASS");
		end else begin
			$display("quadrature_count_diff_drive_odometry_core_tb: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
